// File: rtl/core/fwc_pkg.sv
// Package for flat_index_to_wrapped_coords: widths, register codes, types, helpers.
// No dependencies; used by every other file of the block.
`default_nettype none
package fwc_pkg;

    localparam int IDX_W      = 24;
    localparam int LEN_W      = 13;
    localparam int PER_W      = 11;
    localparam int COORD_W    = 14;
    localparam int WRAP_W     = 10;
    localparam int REM_W      = 13;
    localparam int MAG_W      = 13;
    localparam int XPART_W    = 12;
    localparam int SIDE_W     = 3 * COORD_W + 4;
    localparam int XPART_MAX  = 4095;
    localparam int LEN_MAX    = 4096;
    localparam int MAX_PERIOD = 1024;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef enum logic [2:0] {
        REG_BEGIN_X  = 3'd0,
        REG_BEGIN_Y  = 3'd1,
        REG_BEGIN_Z  = 3'd2,
        REG_LEN_Y    = 3'd3,
        REG_LEN_Z    = 3'd4,
        REG_PERIOD_X = 3'd5,
        REG_PERIOD_Y = 3'd6,
        REG_PERIOD_Z = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] begin_x;
        logic [LEN_W-1:0] begin_y;
        logic [LEN_W-1:0] begin_z;
        logic [LEN_W-1:0] len_y;
        logic [LEN_W-1:0] len_z;
        logic [PER_W-1:0] period_x;
        logic [PER_W-1:0] period_y;
        logic [PER_W-1:0] period_z;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  word;
        logic [REM_W-1:0]  rem;
        logic [SIDE_W-1:0] side;
    } t_cell;

    function automatic logic [REM_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [REM_W-1:0] r;
        if (v == '0) begin
            r = REM_W'(1);
        end else if (v > LEN_W'(LEN_MAX)) begin
            r = REM_W'(LEN_MAX);
        end else begin
            r = REM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [REM_W-1:0] eff_period(input logic [PER_W-1:0] v);
        logic [REM_W-1:0] r;
        if (v == '0) begin
            r = REM_W'(1);
        end else if (v > PER_W'(MAX_PERIOD)) begin
            r = REM_W'(MAX_PERIOD);
        end else begin
            r = REM_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fwc_if.sv
// Stream interfaces for the point-number input and coordinate output channels.
// Depends on fwc_pkg for field widths.
`default_nettype none
interface fwc_in_if;
    logic                     valid;
    logic                     ready;
    logic [fwc_pkg::IDX_W-1:0] flat_index;
    modport source (output valid, output flat_index, input ready);
    modport sink   (input valid, input flat_index, output ready);
endinterface

interface fwc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fwc_pkg::COORD_W-1:0] coord_x;
    logic signed [fwc_pkg::COORD_W-1:0] coord_y;
    logic signed [fwc_pkg::COORD_W-1:0] coord_z;
    logic [fwc_pkg::WRAP_W-1:0]         wrapped_x;
    logic [fwc_pkg::WRAP_W-1:0]         wrapped_y;
    logic [fwc_pkg::WRAP_W-1:0]         wrapped_z;
    logic                               overflow;
    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output wrapped_x, output wrapped_y, output wrapped_z,
                    output overflow, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input wrapped_x, input wrapped_y, input wrapped_z,
                    input overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fwc_div_cell.sv
// One restoring-division cell: shifts one dividend bit into the remainder per beat.
// Depends on fwc_pkg for the cell record type.
`default_nettype none
module fwc_div_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [fwc_pkg::REM_W-1:0]   i_divisor,
    input  wire fwc_pkg::t_cell              i_cell,
    output fwc_pkg::t_cell                   o_cell
);
    fwc_pkg::t_cell r_cell;
    fwc_pkg::t_cell n_cell;
    logic [fwc_pkg::REM_W:0] trial;
    logic [fwc_pkg::REM_W:0] diff;
    logic                    ge;

    always_comb begin
        trial = {i_cell.rem, i_cell.word[fwc_pkg::IDX_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
        n_cell       = i_cell;
        n_cell.rem   = ge ? diff[fwc_pkg::REM_W-1:0] : trial[fwc_pkg::REM_W-1:0];
        n_cell.word  = {i_cell.word[fwc_pkg::IDX_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell.word <= n_cell.word;
            r_cell.rem  <= n_cell.rem;
            r_cell.side <= n_cell.side;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// File: rtl/core/fwc_apb_regs.sv
// APB register file holding box start, box lengths and grid periods.
// Depends on fwc_pkg for register codes and the configuration record.
`default_nettype none
module fwc_apb_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fwc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fwc_pkg::DATA_W-1:0]   pwdata,
    output logic      [fwc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output fwc_pkg::t_cfg                     o_cfg
);
    fwc_pkg::t_cfg    r_cfg;
    fwc_pkg::t_reg_idx idx;
    logic             wr;

    assign idx    = fwc_pkg::t_reg_idx'(paddr[fwc_pkg::ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.begin_x  <= '0;
            r_cfg.begin_y  <= '0;
            r_cfg.begin_z  <= '0;
            r_cfg.len_y    <= fwc_pkg::LEN_W'(1);
            r_cfg.len_z    <= fwc_pkg::LEN_W'(1);
            r_cfg.period_x <= fwc_pkg::PER_W'(1);
            r_cfg.period_y <= fwc_pkg::PER_W'(1);
            r_cfg.period_z <= fwc_pkg::PER_W'(1);
        end else if (wr) begin
            unique case (idx)
                fwc_pkg::REG_BEGIN_X:  r_cfg.begin_x  <= pwdata[fwc_pkg::LEN_W-1:0];
                fwc_pkg::REG_BEGIN_Y:  r_cfg.begin_y  <= pwdata[fwc_pkg::LEN_W-1:0];
                fwc_pkg::REG_BEGIN_Z:  r_cfg.begin_z  <= pwdata[fwc_pkg::LEN_W-1:0];
                fwc_pkg::REG_LEN_Y:    r_cfg.len_y    <= pwdata[fwc_pkg::LEN_W-1:0];
                fwc_pkg::REG_LEN_Z:    r_cfg.len_z    <= pwdata[fwc_pkg::LEN_W-1:0];
                fwc_pkg::REG_PERIOD_X: r_cfg.period_x <= pwdata[fwc_pkg::PER_W-1:0];
                fwc_pkg::REG_PERIOD_Y: r_cfg.period_y <= pwdata[fwc_pkg::PER_W-1:0];
                fwc_pkg::REG_PERIOD_Z: r_cfg.period_z <= pwdata[fwc_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            fwc_pkg::REG_BEGIN_X:  prdata = fwc_pkg::DATA_W'(r_cfg.begin_x);
            fwc_pkg::REG_BEGIN_Y:  prdata = fwc_pkg::DATA_W'(r_cfg.begin_y);
            fwc_pkg::REG_BEGIN_Z:  prdata = fwc_pkg::DATA_W'(r_cfg.begin_z);
            fwc_pkg::REG_LEN_Y:    prdata = fwc_pkg::DATA_W'(r_cfg.len_y);
            fwc_pkg::REG_LEN_Z:    prdata = fwc_pkg::DATA_W'(r_cfg.len_z);
            fwc_pkg::REG_PERIOD_X: prdata = fwc_pkg::DATA_W'(r_cfg.period_x);
            fwc_pkg::REG_PERIOD_Y: prdata = fwc_pkg::DATA_W'(r_cfg.period_y);
            fwc_pkg::REG_PERIOD_Z: prdata = fwc_pkg::DATA_W'(r_cfg.period_z);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: rtl/core/flat_index_to_wrapped_coords_top.sv
// Top level: flat point number to box coordinates with periodic wrap.
// Depends on fwc_pkg, fwc_if, fwc_div_cell and fwc_apb_regs.
//
// Usage:
//   i_in carries one flat_index per beat; o_res carries one result beat per
//   input beat: unwrapped coord_x/y/z, wrapped_x/y/z and overflow. Registers are written
//   over the APB port (byte address 4*index); the user must do so only while idle, the block does not check it.
// Pipeline: a chain of 24 division cells by len_z, 24 cells by len_y, a
//   coordinate stage, 13 cells per axis for the period remainder and an
//   output register.
// Throughput: one beat per cycle while o_res is not stalled; every cell takes a new beat each cycle the chain advances.
// Reset: synchronous, active low; clears all valid bits and loads register
//   defaults (starts 0, lengths and periods 1).
// Stall: when o_res is valid and not ready the whole chain holds and
//   i_in.ready drops in the same cycle; no beat is lost.
`default_nettype none
module flat_index_to_wrapped_coords_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    fwc_in_if.sink                           i_in,
    fwc_out_if.source                        o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fwc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fwc_pkg::DATA_W-1:0]  pwdata,
    output logic      [fwc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    localparam int NA = fwc_pkg::IDX_W;
    localparam int NW = fwc_pkg::MAG_W;
    localparam int CW = fwc_pkg::COORD_W;

    fwc_pkg::t_cfg  cfg;
    logic           adv;
    logic [fwc_pkg::REM_W-1:0] lz, ly, per_x, per_y, per_z;

    fwc_pkg::t_cell ca [NA+1];
    fwc_pkg::t_cell cb [NA+1];
    fwc_pkg::t_cell wx [NW+1];
    fwc_pkg::t_cell wy [NW+1];
    fwc_pkg::t_cell wz [NW+1];

    logic                     r_prep_valid;
    logic signed [CW-1:0]     r_cx, r_cy, r_cz;
    logic                     r_ovf;
    logic [fwc_pkg::IDX_W-1:0]   px;
    logic [fwc_pkg::XPART_W-1:0] px_sat;
    logic                     ovf;
    logic signed [CW-1:0]     n_cx, n_cy, n_cz;
    logic [NW-1:0]            mag_x, mag_y, mag_z;

    logic                     r_out_valid;
    logic signed [CW-1:0]     r_ox, r_oy, r_oz;
    logic [fwc_pkg::WRAP_W-1:0] r_wx, r_wy, r_wz;
    logic                     r_oovf;
    logic [fwc_pkg::REM_W-1:0] fx, fy, fz;

    fwc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign lz    = fwc_pkg::eff_len(cfg.len_z);
    assign ly    = fwc_pkg::eff_len(cfg.len_y);
    assign per_x = fwc_pkg::eff_period(cfg.period_x);
    assign per_y = fwc_pkg::eff_period(cfg.period_y);
    assign per_z = fwc_pkg::eff_period(cfg.period_z);

    assign adv        = !r_out_valid || o_res.ready;
    assign i_in.ready = adv;

    // divide by len_z
    always_comb begin
        ca[0].valid = i_in.valid;
        ca[0].word  = i_in.flat_index;
        ca[0].rem   = '0;
        ca[0].side  = '0;
    end

    for (genvar k = 0; k < NA; k++) begin : g_a
        fwc_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_divisor(lz), .i_cell(ca[k]), .o_cell(ca[k+1])
        );
    end

    // divide quotient by len_y, z part rides along
    always_comb begin
        cb[0].valid = ca[NA].valid;
        cb[0].word  = ca[NA].word;
        cb[0].rem   = '0;
        cb[0].side  = fwc_pkg::SIDE_W'(ca[NA].rem);
    end

    for (genvar k = 0; k < NA; k++) begin : g_b
        fwc_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_divisor(ly), .i_cell(cb[k]), .o_cell(cb[k+1])
        );
    end

    // saturate x part and add box start
    always_comb begin
        px     = cb[NA].word;
        ovf    = (px > fwc_pkg::IDX_W'(fwc_pkg::XPART_MAX));
        px_sat = ovf ? fwc_pkg::XPART_W'(fwc_pkg::XPART_MAX) : fwc_pkg::XPART_W'(px);
        n_cx   = $signed(CW'(px_sat)) + CW'($signed(cfg.begin_x));
        n_cy   = $signed(CW'(cb[NA].rem)) + CW'($signed(cfg.begin_y));
        n_cz   = $signed(CW'(cb[NA].side[fwc_pkg::REM_W-1:0])) + CW'($signed(cfg.begin_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (adv) begin
            r_prep_valid <= cb[NA].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_cz  <= n_cz;
            r_ovf <= ovf;
        end
    end

    // magnitude remainder per axis, sign fixed at the end
    assign mag_x = r_cx[CW-1] ? NW'(-r_cx) : NW'(r_cx);
    assign mag_y = r_cy[CW-1] ? NW'(-r_cy) : NW'(r_cy);
    assign mag_z = r_cz[CW-1] ? NW'(-r_cz) : NW'(r_cz);

    always_comb begin
        wx[0].valid = r_prep_valid;
        wx[0].word  = fwc_pkg::IDX_W'(mag_x) << (fwc_pkg::IDX_W - NW);
        wx[0].rem   = '0;
        wx[0].side  = {r_ovf, r_cz[CW-1], r_cy[CW-1], r_cx[CW-1], r_cz, r_cy, r_cx};
        wy[0].valid = r_prep_valid;
        wy[0].word  = fwc_pkg::IDX_W'(mag_y) << (fwc_pkg::IDX_W - NW);
        wy[0].rem   = '0;
        wy[0].side  = '0;
        wz[0].valid = r_prep_valid;
        wz[0].word  = fwc_pkg::IDX_W'(mag_z) << (fwc_pkg::IDX_W - NW);
        wz[0].rem   = '0;
        wz[0].side  = '0;
    end

    for (genvar k = 0; k < NW; k++) begin : g_w
        fwc_div_cell u_cx (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_divisor(per_x), .i_cell(wx[k]), .o_cell(wx[k+1])
        );
        fwc_div_cell u_cy (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_divisor(per_y), .i_cell(wy[k]), .o_cell(wy[k+1])
        );
        fwc_div_cell u_cz (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_divisor(per_z), .i_cell(wz[k]), .o_cell(wz[k+1])
        );
    end

    // negative coordinate with nonzero remainder wraps to period - rem
    always_comb begin
        fx = (wx[NW].side[3*CW] && wx[NW].rem != '0) ? per_x - wx[NW].rem : wx[NW].rem;
        fy = (wx[NW].side[3*CW+1] && wy[NW].rem != '0) ? per_y - wy[NW].rem : wy[NW].rem;
        fz = (wx[NW].side[3*CW+2] && wz[NW].rem != '0) ? per_z - wz[NW].rem : wz[NW].rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= wx[NW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox   <= wx[NW].side[CW-1:0];
            r_oy   <= wx[NW].side[2*CW-1:CW];
            r_oz   <= wx[NW].side[3*CW-1:2*CW];
            r_oovf <= wx[NW].side[3*CW+3];
            r_wx   <= fwc_pkg::WRAP_W'(fx);
            r_wy   <= fwc_pkg::WRAP_W'(fy);
            r_wz   <= fwc_pkg::WRAP_W'(fz);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.coord_x   = r_ox;
    assign o_res.coord_y   = r_oy;
    assign o_res.coord_z   = r_oz;
    assign o_res.wrapped_x = r_wx;
    assign o_res.wrapped_y = r_wy;
    assign o_res.wrapped_z = r_wz;
    assign o_res.overflow  = r_oovf;
endmodule
`default_nettype wire
